// ----- hw/rtl/tfn_pkg.sv -----
`default_nettype none
package tfn_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int THRESH_W         = 35;
   localparam int OUT_W            = NORMAL_FRAC_BITS + 2;
   localparam int EDGE_W           = COORD_WIDTH + 1;
   localparam int PROD_W           = 2 * EDGE_W;
   localparam int NORM_W           = PROD_W + 1;
   localparam int MAG_W            = PROD_W;
   localparam int SPLIT            = (MAG_W + 1) / 2;
   localparam int PART_W           = 2 * (MAG_W - SPLIT > SPLIT ? MAG_W - SPLIT : SPLIT);
   localparam int LEN_W            = MAG_W + 1;
   localparam int SQ_W             = 2 * LEN_W;
   localparam int REM_W            = LEN_W + 2;
   localparam int DREM_W           = LEN_W + 1;
   localparam int Q_W              = NORMAL_FRAC_BITS + 1;
   localparam int DIV_STAGES       = NORMAL_FRAC_BITS + 1;
   localparam int CMP_W            = (LEN_W > THRESH_W ? LEN_W : THRESH_W) + 1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] norm_x;
      logic signed [OUT_W-1:0] norm_y;
      logic signed [OUT_W-1:0] norm_z;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [SQ_W-1:0]       sum;
   } front_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [LEN_W-1:0]      len;
   } root_type;

endpackage
`default_nettype wire

// ----- hw/rtl/tfn_front.sv -----
`default_nettype none
module tfn_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire tfn_pkg::req_type   in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output tfn_pkg::front_type      out_data
);
   import tfn_pkg::*;

   localparam int NSTG = 6;

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   logic signed [EDGE_W-1:0] e_ff [6];
   logic signed [EDGE_W-1:0] e_in [6];
   logic signed [PROD_W-1:0] p_ff [6];
   logic signed [PROD_W-1:0] p_in [6];
   logic [2:0][MAG_W-1:0]    m2_ff, m2_in, m3_ff, m4_ff, m5_ff;
   logic [2:0]               n2_ff, n2_in, n3_ff, n4_ff, n5_ff;
   logic [PART_W-1:0]        pp_ff [3][3];
   logic [PART_W-1:0]        pp_in [3][3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic [SQ_W-1:0]          sq_in [3];
   logic [SQ_W-1:0]          sum_ff, sum_in;
   logic signed [NORM_W-1:0] n_raw [3];

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? in_valid : v_ff[i-1];
            end
         end
      end
   end

   // edges from the first corner
   always_comb begin
      e_in[0] = EDGE_W'(in_data.b_x) - EDGE_W'(in_data.a_x);
      e_in[1] = EDGE_W'(in_data.b_y) - EDGE_W'(in_data.a_y);
      e_in[2] = EDGE_W'(in_data.b_z) - EDGE_W'(in_data.a_z);
      e_in[3] = EDGE_W'(in_data.c_x) - EDGE_W'(in_data.a_x);
      e_in[4] = EDGE_W'(in_data.c_y) - EDGE_W'(in_data.a_y);
      e_in[5] = EDGE_W'(in_data.c_z) - EDGE_W'(in_data.a_z);
   end

   // cross product terms
   always_comb begin
      p_in[0] = PROD_W'(e_ff[1]) * PROD_W'(e_ff[5]);
      p_in[1] = PROD_W'(e_ff[2]) * PROD_W'(e_ff[4]);
      p_in[2] = PROD_W'(e_ff[2]) * PROD_W'(e_ff[3]);
      p_in[3] = PROD_W'(e_ff[0]) * PROD_W'(e_ff[5]);
      p_in[4] = PROD_W'(e_ff[0]) * PROD_W'(e_ff[4]);
      p_in[5] = PROD_W'(e_ff[1]) * PROD_W'(e_ff[3]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_raw[i] = NORM_W'(p_ff[2*i]) - NORM_W'(p_ff[2*i+1]);
         n2_in[i] = n_raw[i][NORM_W-1];
         m2_in[i] = n2_in[i] ? MAG_W'(-n_raw[i]) : MAG_W'(n_raw[i]);
      end
   end

   // squares split into half-width partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp_in[i][0] = PART_W'(m2_ff[i][MAG_W-1:SPLIT]) * PART_W'(m2_ff[i][MAG_W-1:SPLIT]);
         pp_in[i][1] = PART_W'(m2_ff[i][MAG_W-1:SPLIT]) * PART_W'(m2_ff[i][SPLIT-1:0]);
         pp_in[i][2] = PART_W'(m2_ff[i][SPLIT-1:0]) * PART_W'(m2_ff[i][SPLIT-1:0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQ_W'(pp_ff[i][0]) << (2 * SPLIT))
                  + (SQ_W'(pp_ff[i][1]) << (SPLIT + 1))
                  + SQ_W'(pp_ff[i][2]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e_ff <= e_in;
      end
      if (en[1]) begin
         p_ff <= p_in;
      end
      if (en[2]) begin
         m2_ff <= m2_in;
         n2_ff <= n2_in;
      end
      if (en[3]) begin
         pp_ff <= pp_in;
         m3_ff <= m2_ff;
         n3_ff <= n2_ff;
      end
      if (en[4]) begin
         sq_ff <= sq_in;
         m4_ff <= m3_ff;
         n4_ff <= n3_ff;
      end
      if (en[5]) begin
         sum_ff <= sum_in;
         m5_ff  <= m4_ff;
         n5_ff  <= n4_ff;
      end
   end

   assign out_data.mag = m5_ff;
   assign out_data.neg = n5_ff;
   assign out_data.sum = sum_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/tfn_sqrt.sv -----
`default_nettype none
module tfn_sqrt (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire tfn_pkg::front_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output tfn_pkg::root_type        out_data
);
   import tfn_pkg::*;

   localparam int NSTG = LEN_W;

   logic [NSTG-1:0]       v_ff;
   logic [NSTG-1:0]       en;
   logic [REM_W-1:0]      rem_ff  [NSTG];
   logic [REM_W-1:0]      rem_in  [NSTG];
   logic [LEN_W-1:0]      root_ff [NSTG];
   logic [LEN_W-1:0]      root_in [NSTG];
   logic [SQ_W-1:0]       rad_ff  [NSTG];
   logic [SQ_W-1:0]       rad_in  [NSTG];
   logic [2:0][MAG_W-1:0] mag_ff  [NSTG];
   logic [2:0]            neg_ff  [NSTG];

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTG-1];

   // one root bit per stage, two radicand bits shifted in
   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      logic [REM_W-1:0] rem_prev;
      logic [LEN_W-1:0] root_prev;
      logic [SQ_W-1:0]  rad_prev;
      logic [REM_W-1:0] part;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_data.sum;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      always_comb begin
         part       = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1 -: 2]};
         trial      = {root_prev, 2'b01};
         ge         = part >= trial;
         rem_in[k]  = ge ? part - trial : part;
         root_in[k] = {root_prev[LEN_W-2:0], ge};
         rad_in[k]  = rad_prev << 2;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            mag_ff[k]  <= (k == 0) ? in_data.mag : mag_ff[k-1];
            neg_ff[k]  <= (k == 0) ? in_data.neg : neg_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? in_valid : v_ff[i-1];
            end
         end
      end
   end

   assign out_data.mag = mag_ff[NSTG-1];
   assign out_data.neg = neg_ff[NSTG-1];
   assign out_data.len = root_ff[NSTG-1];

endmodule
`default_nettype wire

// ----- hw/rtl/tfn_div.sv -----
`default_nettype none
module tfn_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [tfn_pkg::THRESH_W-1:0] threshold,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire tfn_pkg::root_type      in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output tfn_pkg::rsp_type            out_data
);
   import tfn_pkg::*;

   localparam int NSTG = DIV_STAGES + 1;

   logic [NSTG-1:0]         v_ff;
   logic [NSTG-1:0]         en;
   logic [2:0][DREM_W-1:0]  rem_ff [DIV_STAGES];
   logic [2:0][DREM_W-1:0]  rem_in [DIV_STAGES];
   logic [2:0][Q_W-1:0]     q_ff   [DIV_STAGES];
   logic [2:0][Q_W-1:0]     q_in   [DIV_STAGES];
   logic [LEN_W-1:0]        len_ff [DIV_STAGES];
   logic [2:0]              neg_ff [DIV_STAGES];
   logic                    deg_ff [DIV_STAGES];
   logic                    deg_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [2:0][OUT_W-1:0]   comp;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTG-1];

   assign deg_in = CMP_W'(in_data.len) <= CMP_W'(threshold);

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [2:0][DREM_W-1:0] part;
      logic [LEN_W-1:0]       len_cur;
      logic [2:0]             ge;

      if (k == 0) begin : g_first
         assign len_cur = in_data.len;
         always_comb begin
            for (int c = 0; c < 3; c++) begin
               part[c] = DREM_W'(in_data.mag[c]);
            end
         end
      end else begin : g_next
         assign len_cur = len_ff[k-1];
         always_comb begin
            for (int c = 0; c < 3; c++) begin
               part[c] = rem_ff[k-1][c] << 1;
            end
         end
      end

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            ge[c]        = part[c] >= DREM_W'(len_cur);
            rem_in[k][c] = ge[c] ? part[c] - DREM_W'(len_cur) : part[c];
            if (k == 0) begin
               q_in[k][c] = Q_W'(ge[c]);
            end else begin
               q_in[k][c] = {q_ff[k-1][c][Q_W-2:0], ge[c]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            len_ff[k] <= len_cur;
            neg_ff[k] <= (k == 0) ? in_data.neg : neg_ff[k-1];
            deg_ff[k] <= (k == 0) ? deg_in : deg_ff[k-1];
         end
      end
   end

   // round half away from zero, then apply sign
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         comp[c] = OUT_W'(q_ff[DIV_STAGES-1][c])
                 + OUT_W'({rem_ff[DIV_STAGES-1][c], 1'b0} >= (DREM_W + 1)'(len_ff[DIV_STAGES-1]));
         if (neg_ff[DIV_STAGES-1][c]) begin
            comp[c] = -comp[c];
         end
         if (deg_ff[DIV_STAGES-1]) begin
            comp[c] = '0;
         end
      end
      rsp_in.norm_x     = comp[0];
      rsp_in.norm_y     = comp[1];
      rsp_in.norm_z     = comp[2];
      rsp_in.degenerate = deg_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? in_valid : v_ff[i-1];
            end
         end
      end
   end

   assign out_data = rsp_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/triangle_face_normal.sv -----
// Unit face normal of a triangle given as three signed Q7.8 corners, returned as
// signed Q1.14 components with a degenerate flag when the cross product length
// is at or below csr threshold (units of 2^-16). Fully pipelined: one triangle
// per clock while the response side does not stall, through edges, cross product
// and squared length, square root at one root bit per stage, division at one
// quotient bit per stage, then rounding and output register. Stalls on the
// response side propagate back stage by stage, so empty stages still fill while
// a result waits.
`default_nettype none
module triangle_face_normal (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire tfn_pkg::req_type              req,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output tfn_pkg::rsp_type                   rsp,
   input  wire logic                          csr_wr_en,
   input  wire logic [tfn_pkg::THRESH_W-1:0]  csr_wr_data
);
   import tfn_pkg::*;

   logic [THRESH_W-1:0] threshold_ff;
   logic                front_valid, front_ready;
   front_type           front_data;
   logic                root_valid, root_ready;
   root_type            root_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_data  (root_data)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_data   (root_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.degenerate |-> rsp.norm_x == '0 && rsp.norm_y == '0 && rsp.norm_z == '0)
      else $error("degenerate transaction with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.norm_x <= OUT_W'(1 << NORMAL_FRAC_BITS)
                 && rsp.norm_x >= -OUT_W'(1 << NORMAL_FRAC_BITS)
                 && rsp.norm_y <= OUT_W'(1 << NORMAL_FRAC_BITS)
                 && rsp.norm_y >= -OUT_W'(1 << NORMAL_FRAC_BITS)
                 && rsp.norm_z <= OUT_W'(1 << NORMAL_FRAC_BITS)
                 && rsp.norm_z >= -OUT_W'(1 << NORMAL_FRAC_BITS))
      else $error("normal component out of unit range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
`default_nettype wire
